>>> sv/isrb_pkg.sv
`timescale 1ns / 1ps

package isrb_pkg;

   // Default depth of the register bank
   localparam int REG_COUNT_DEFAULT = 128;

   // Bus operation codes
   localparam logic [2:0] OP_WR_START = 3'd0;
   localparam logic [2:0] OP_RD_START = 3'd1;
   localparam logic [2:0] OP_WR_BYTE  = 3'd2;
   localparam logic [2:0] OP_RD_BYTE  = 3'd3;
   localparam logic [2:0] OP_INJECT   = 3'd4;

   // Register map
   localparam logic [7:0] ADDR_DATA0_MSB = 8'h00;
   localparam logic [7:0] ADDR_DATA0_LSB = 8'h01;
   localparam logic [7:0] ADDR_DATA1_MSB = 8'h02;
   localparam logic [7:0] ADDR_DATA1_LSB = 8'h03;
   localparam logic [7:0] ADDR_STATUS    = 8'h18;
   localparam logic [7:0] ADDR_ERRCFG    = 8'h19;
   localparam logic [7:0] ADDR_CONFIG    = 8'h1A;
   localparam logic [7:0] ADDR_MUXCFG    = 8'h1B;
   localparam logic [7:0] ADDR_RESETDEV  = 8'h1C;
   localparam logic [7:0] ADDR_MFR_ID    = 8'h7E;
   localparam logic [7:0] ADDR_DEV_ID    = 8'h7F;

   // Reset values
   localparam logic [15:0] CONFIG_DEFAULT = 16'h2801;
   localparam logic [15:0] MUXCFG_DEFAULT = 16'h020C;
   localparam logic [15:0] MFR_ID_VALUE   = 16'h5449;
   localparam logic [15:0] DEV_ID_VALUE   = 16'h3055;

   // STATUS bit positions
   localparam int STATUS_DRDY_BIT = 6;

   function automatic logic [15:0] reg_default(input logic [7:0] addr);
      logic [15:0] val;
      val = 16'h0000;
      case (addr)
         ADDR_CONFIG: val = CONFIG_DEFAULT;
         ADDR_MUXCFG: val = MUXCFG_DEFAULT;
         ADDR_MFR_ID: val = MFR_ID_VALUE;
         ADDR_DEV_ID: val = DEV_ID_VALUE;
         default:     val = 16'h0000;
      endcase
      return val;
   endfunction

   // Registers that ignore bus writes
   function automatic logic is_locked(input logic [7:0] addr);
      return (addr <= ADDR_DATA1_LSB) || (addr == ADDR_STATUS) ||
             (addr == ADDR_MFR_ID) || (addr == ADDR_DEV_ID);
   endfunction

endpackage

>>> sv/isrb_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read, old data on a same-address collision
module isrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/i2c_sensor_register_bank_core.sv
`timescale 1ns / 1ps
// An accepted request reaches its response through the input register and the result register.
// One item per cycle unless the response stalls; the registers decouple the two sides.
// Reset (synchronous): control state, pointer, phase and the flop-held registers return to
//   their defaults at once; the per-entry valid bits clear in the same cycle, so the RAM bank
//   reads as its defaults straight away with no clearing pass. A soft reset via 0x1C reloads
//   the bank the same way, but the pointer steps on, phase returns to MSB, start flag is kept.
module i2c_sensor_register_bank_core
   import isrb_pkg::*;
#(
   parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_bus_byte,
   input  logic        req_channel,
   input  logic [27:0] req_sample,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nak,
   output logic        rsp_irq_n
);

   localparam int         AW        = $clog2(REG_COUNT);
   localparam logic [8:0] REG_LIMIT = 9'(REG_COUNT);

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_op_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_channel_ff;
   logic [27:0] s1_sample_ff;

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_read_data_ff;
   logic        rsp_nak_ff;
   logic        rsp_irq_n_ff;

   // ------------------------------------------------------------------
   // Bus-side state
   // ------------------------------------------------------------------
   logic [7:0]  ptr_ff, ptr_in;
   logic        phase_ff, phase_in;      // 0: MSB next
   logic        expect_ff, expect_in;    // next written byte is the pointer

   // Registers kept in flops: touched by injections or feeding the interrupt every cycle.
   // Data MSB error flags (bits 15:12) are never set, so only 12 bits are stored.
   logic [11:0] data0_hi_ff, data0_hi_in;
   logic [15:0] data0_lo_ff, data0_lo_in;
   logic [11:0] data1_hi_ff, data1_hi_in;
   logic [15:0] data1_lo_ff, data1_lo_in;
   logic        drdy_ff, drdy_in;
   logic [15:0] errcfg_ff, errcfg_in;
   logic [15:0] config_ff, config_in;

   // RAM-backed registers: valid bit per entry, invalid entries read their default
   logic [REG_COUNT-1:0] valid_ff, valid_in;
   logic                 fwd_ff, fwd_in;          // last RAM write hit the new pointer
   logic [15:0]          fwd_data_ff;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [15:0]          ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [15:0]          ram_rdata;

   logic        out_free;
   logic        proc;
   logic        accept;
   logic        in_range;
   logic [15:0] ram_word;
   logic [15:0] word;
   logic [15:0] new_word;
   logic        wr_en_c;
   logic        soft_rst;
   logic [7:0]  rd_c;
   logic        nak_c;
   logic        irq_n_c;

   // ------------------------------------------------------------------
   // Handshake: the item in the input register is processed whenever the
   // result register is free or being emptied in this cycle.
   // ------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept ? 1'b1 : (proc ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = proc ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // ------------------------------------------------------------------
   // Register bank RAM. The read address follows the next pointer, so the
   // word at the pointer is ready once the pointer holds it; a write at the same
   // edge to that address is forwarded.
   // ------------------------------------------------------------------
   assign ram_waddr = ptr_ff[AW-1:0];
   assign ram_raddr = ptr_in[AW-1:0];

   isrb_ram #(
      .WIDTH (16),
      .DEPTH (REG_COUNT)
   ) u_bank (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_word = fwd_ff ? fwd_data_ff :
                     (valid_ff[ptr_ff[AW-1:0]] ? ram_rdata : reg_default(ptr_ff));
   assign in_range = {1'b0, ptr_ff} < REG_LIMIT;

   // Word currently addressed by the pointer
   always_comb begin
      case (ptr_ff)
         ADDR_DATA0_MSB: word = {4'h0, data0_hi_ff};
         ADDR_DATA0_LSB: word = data0_lo_ff;
         ADDR_DATA1_MSB: word = {4'h0, data1_hi_ff};
         ADDR_DATA1_LSB: word = data1_lo_ff;
         ADDR_STATUS:    word = 16'(drdy_ff) << STATUS_DRDY_BIT;
         ADDR_ERRCFG:    word = errcfg_ff;
         ADDR_CONFIG:    word = config_ff;
         ADDR_MFR_ID:    word = MFR_ID_VALUE;
         ADDR_DEV_ID:    word = DEV_ID_VALUE;
         default:        word = ram_word;
      endcase
   end

   // ------------------------------------------------------------------
   // Item processing
   // ------------------------------------------------------------------
   always_comb begin
      ptr_in      = ptr_ff;
      phase_in    = phase_ff;
      expect_in   = expect_ff;
      data0_hi_in = data0_hi_ff;
      data0_lo_in = data0_lo_ff;
      data1_hi_in = data1_hi_ff;
      data1_lo_in = data1_lo_ff;
      drdy_in     = drdy_ff;
      errcfg_in   = errcfg_ff;
      config_in   = config_ff;
      new_word    = word;
      wr_en_c     = 1'b0;
      soft_rst    = 1'b0;
      rd_c        = 8'h00;
      nak_c       = 1'b0;
      ram_we      = 1'b0;
      ram_wdata   = new_word;
      valid_in    = valid_ff;

      if (proc) begin
         case (s1_op_ff)
            OP_WR_START: begin
               expect_in = 1'b1;
               phase_in  = 1'b0;
            end
            OP_RD_START: begin
               phase_in = 1'b0;
            end
            OP_WR_BYTE: begin
               if (expect_ff) begin
                  ptr_in    = s1_byte_ff;
                  expect_in = 1'b0;
                  phase_in  = 1'b0;
               end else if (!in_range) begin
                  nak_c = 1'b1;
               end else begin
                  phase_in = !phase_ff;
                  if (is_locked(ptr_ff)) begin
                     // locked: byte dropped, pointer still steps after the LSB
                     if (phase_ff) begin
                        ptr_in = ptr_ff + 8'd1;
                     end
                  end else if (!phase_ff) begin
                     new_word = {s1_byte_ff, word[7:0]};
                     wr_en_c  = 1'b1;
                  end else begin
                     new_word = {word[15:8], s1_byte_ff};
                     ptr_in   = ptr_ff + 8'd1;
                     // soft reset when 0x1C completes with bit 15 set
                     if (ptr_ff == ADDR_RESETDEV && word[15]) begin
                        soft_rst = 1'b1;
                     end else begin
                        wr_en_c = 1'b1;
                     end
                  end
               end
            end
            OP_RD_BYTE: begin
               if (in_range) begin
                  if (!phase_ff) begin
                     rd_c     = word[15:8];
                     phase_in = 1'b1;
                  end else begin
                     rd_c     = word[7:0];
                     phase_in = 1'b0;
                     ptr_in   = ptr_ff + 8'd1;
                     if (ptr_ff == ADDR_STATUS) begin
                        drdy_in = 1'b0;
                     end
                  end
               end
            end
            OP_INJECT: begin
               if (s1_channel_ff) begin
                  data1_hi_in = s1_sample_ff[27:16];
                  data1_lo_in = s1_sample_ff[15:0];
               end else begin
                  data0_hi_in = s1_sample_ff[27:16];
                  data0_lo_in = s1_sample_ff[15:0];
               end
               config_in[15] = s1_channel_ff;
               drdy_in       = 1'b1;
            end
            default: begin
               // unused codes change nothing
            end
         endcase
      end

      // route a register write to its flop or to the RAM
      if (wr_en_c) begin
         if (ptr_ff == ADDR_ERRCFG) begin
            errcfg_in = new_word;
         end else if (ptr_ff == ADDR_CONFIG) begin
            config_in = new_word;
         end else begin
            ram_we    = 1'b1;
            ram_wdata = new_word;
            valid_in[ram_waddr] = 1'b1;
         end
      end

      if (soft_rst) begin
         data0_hi_in = '0;
         data0_lo_in = '0;
         data1_hi_in = '0;
         data1_lo_in = '0;
         drdy_in     = 1'b0;
         errcfg_in   = '0;
         config_in   = CONFIG_DEFAULT;
         valid_in    = '0;
      end
   end

   assign fwd_in  = ram_we && (ram_waddr == ptr_in[AW-1:0]);
   assign irq_n_c = !(drdy_in && errcfg_in[8] && !config_in[7]);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         phase_ff     <= 1'b0;
         expect_ff    <= 1'b0;
         data0_hi_ff  <= '0;
         data0_lo_ff  <= '0;
         data1_hi_ff  <= '0;
         data1_lo_ff  <= '0;
         drdy_ff      <= 1'b0;
         errcfg_ff    <= '0;
         config_ff    <= CONFIG_DEFAULT;
         valid_ff     <= '0;
         fwd_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         phase_ff     <= phase_in;
         expect_ff    <= expect_in;
         data0_hi_ff  <= data0_hi_in;
         data0_lo_ff  <= data0_lo_in;
         data1_hi_ff  <= data1_hi_in;
         data1_lo_ff  <= data1_lo_in;
         drdy_ff      <= drdy_in;
         errcfg_ff    <= errcfg_in;
         config_ff    <= config_in;
         valid_ff     <= valid_in;
         fwd_ff       <= fwd_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= req_op;
         s1_byte_ff    <= req_bus_byte;
         s1_channel_ff <= req_channel;
         s1_sample_ff  <= req_sample;
      end
      if (proc) begin
         rsp_read_data_ff <= rd_c;
         rsp_nak_ff       <= nak_c;
         rsp_irq_n_ff     <= irq_n_c;
      end
      fwd_data_ff <= ram_wdata;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_nak       = rsp_nak_ff;
   assign rsp_irq_n     = rsp_irq_n_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // a refused byte leaves the pointer where it was
   a_nak_holds_ptr: assert property (@(posedge clock) disable iff (reset)
      proc && nak_c |=> ptr_ff == $past(ptr_ff))
      else $error("pointer moved on a refused byte");

   // the interrupt level in a fresh result matches the stored bank state
   a_irq_matches_state: assert property (@(posedge clock) disable iff (reset)
      proc |=> rsp_irq_n == !(drdy_ff && errcfg_ff[8] && !config_ff[7]))
      else $error("interrupt level disagrees with register state");

   // a forwarded word always belongs to an entry marked as written
   a_fwd_valid: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> valid_ff[ptr_ff[AW-1:0]])
      else $error("forwarded word for an unwritten entry");

   // a read start always leaves the MSB next
   a_rd_start_phase: assert property (@(posedge clock) disable iff (reset)
      proc && s1_op_ff == OP_RD_START |=> !phase_ff)
      else $error("byte phase not cleared by read start");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
   import isrb_pkg::*;

   // Op codes that the block treats as no-ops
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam int RANDOM_ITEMS = 420;
   localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
   localparam int QUIET_LIMIT  = 2000;  // watchdog: cycles without any transfer
   localparam int DRAIN_CYCLES = 8;     // margin after the last expected response
   localparam int BANK_AW      = $clog2(REG_COUNT_DEFAULT);

   typedef struct packed {
      logic [7:0] read_data;
      logic       nak;
      logic       irq_n;
   } bank_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_op;
   logic [7:0]  req_bus_byte;
   logic        req_channel;
   logic [27:0] req_sample;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_read_data;
   logic        rsp_nak;
   logic        rsp_irq_n;

   // Predicted state of the target: bank, pointer, byte phase, pointer-byte flag
   logic [15:0] bank_model [0:REG_COUNT_DEFAULT-1];
   logic [7:0]  ptr_model;
   logic        lsb_next;
   logic        ptr_pending;

   bank_rsp_type pending_rsp [$];

   int error_count;
   int req_count;
   int rsp_count;
   int sent_count;
   int inject_count;
   int soft_reset_count;
   int nak_count;
   int irq_low_count;

   // Sender burst control and receiver hold-off request
   int   burst_left;
   bit   gaps_on;
   bit   long_hold_req;
   bit   hold_done;
   int   rx_cycle;
   int   stall_run;

   i2c_sensor_register_bank_core #(
      .REG_COUNT(REG_COUNT_DEFAULT)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_bus_byte  (req_bus_byte),
      .req_channel   (req_channel),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_nak       (rsp_nak),
      .rsp_irq_n     (rsp_irq_n)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Bank index of an in-range register address
   function automatic logic [BANK_AW-1:0] bidx(input logic [7:0] addr);
      return addr[BANK_AW-1:0];
   endfunction

   // Power-on contents; also what a soft reset through 0x1C brings back
   function automatic void load_bank_defaults();
      bank_model = '{default: 16'h0000};
      bank_model[bidx(ADDR_CONFIG)] = CONFIG_DEFAULT;
      bank_model[bidx(ADDR_MUXCFG)] = MUXCFG_DEFAULT;
      bank_model[bidx(ADDR_MFR_ID)] = MFR_ID_VALUE;
      bank_model[bidx(ADDR_DEV_ID)] = DEV_ID_VALUE;
   endfunction

   // Advances the predicted state by one bus operation and returns the response
   function automatic bank_rsp_type predict_bank_access(input logic [2:0] op,
                                                        input logic [7:0] data_byte,
                                                        input logic ch,
                                                        input logic [27:0] smp);
      bank_rsp_type r;
      logic [7:0]   p;
      logic         was_msb;
      logic         locked;
      logic [7:0]   hi;
      logic [7:0]   lo;
      r = '0;
      p = ptr_model;
      case (op)
         OP_WR_START: begin
            ptr_pending = 1'b1;
            lsb_next    = 1'b0;
         end
         OP_RD_START: begin
            lsb_next = 1'b0;
         end
         OP_WR_BYTE: begin
            if (ptr_pending) begin
               ptr_model   = data_byte;
               ptr_pending = 1'b0;
               lsb_next    = 1'b0;
            end else if (p >= REG_COUNT_DEFAULT) begin
               r.nak = 1'b1;
            end else begin
               was_msb  = !lsb_next;
               lsb_next = !lsb_next;
               // data words, STATUS and the ID words drop written bytes
               locked = (p <= ADDR_DATA1_LSB) || (p == ADDR_STATUS) ||
                        (p == ADDR_MFR_ID) || (p == ADDR_DEV_ID);
               if (locked) begin
                  if (!was_msb)
                     ptr_model = p + 8'd1;
               end else if (was_msb) begin
                  bank_model[bidx(p)][15:8] = data_byte;
               end else begin
                  bank_model[bidx(p)][7:0] = data_byte;
                  if (p == ADDR_RESETDEV && bank_model[bidx(p)][15]) begin
                     load_bank_defaults();
                     soft_reset_count++;
                  end
                  ptr_model = p + 8'd1;
               end
            end
         end
         OP_RD_BYTE: begin
            if (p < REG_COUNT_DEFAULT) begin
               if (!lsb_next) begin
                  r.read_data = bank_model[bidx(p)][15:8];
                  lsb_next    = 1'b1;
               end else begin
                  r.read_data = bank_model[bidx(p)][7:0];
                  lsb_next    = 1'b0;
                  if (p == ADDR_STATUS)
                     bank_model[bidx(ADDR_STATUS)][STATUS_DRDY_BIT] = 1'b0;
                  ptr_model = p + 8'd1;
               end
            end
         end
         OP_INJECT: begin
            hi = ch ? ADDR_DATA1_MSB : ADDR_DATA0_MSB;
            lo = ch ? ADDR_DATA1_LSB : ADDR_DATA0_LSB;
            bank_model[bidx(hi)][11:0] = smp[27:16];
            bank_model[bidx(lo)]       = smp[15:0];
            bank_model[bidx(ADDR_CONFIG)][15] = ch;
            bank_model[bidx(ADDR_STATUS)][STATUS_DRDY_BIT] = 1'b1;
            inject_count++;
         end
         default: ;
      endcase
      r.irq_n = !(bank_model[bidx(ADDR_STATUS)][STATUS_DRDY_BIT] &&
                  bank_model[bidx(ADDR_ERRCFG)][8] &&
                  !bank_model[bidx(ADDR_CONFIG)][7]);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at response %0d, %s: got 0x%0h, want 0x%0h",
               rsp_count, what, got, want);
      error_count++;
   endtask

   // One request transfer. Called at a falling edge; returns at the falling edge after
   // acceptance. Bursts of back-to-back transfers are separated by random gaps while gaps_on is set.
   task automatic send_req(input logic [2:0] op, input logic [7:0] data_byte,
                           input logic ch, input logic [27:0] smp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(16, 1);
         gap = gaps_on ? $urandom_range(6, 0) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_bus_byte <= data_byte;
      req_channel  <= ch;
      req_sample   <= smp;
      // payload stays put until the transfer happens
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
      sent_count++;
   endtask

   // Same, with random content in every field the op ignores or leaves free
   task automatic send_op(input logic [2:0] op);
      send_req(op, 8'($urandom), 1'($urandom), 28'($urandom));
   endtask

   // Pointer choice: mostly the populated low map, some near the top, some anywhere
   function automatic logic [7:0] pick_reg_ptr();
      int sel;
      sel = $urandom_range(99, 0);
      if (sel < 70)
         return 8'($urandom_range(8'h1F, 8'h00));
      else if (sel < 85)
         return 8'($urandom_range(8'h80, 8'h7C));
      return 8'($urandom_range(255, 0));
   endfunction

   // Response monitor: predicts on each request transfer, checks each response transfer.
   // Both sides are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      bank_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_rsp.push_back(predict_bank_access(req_op, req_bus_byte, req_channel,
                                                      req_sample));
            req_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (!rsp_irq_n)
               irq_low_count++;
            if (rsp_nak)
               nak_count++;
            if (pending_rsp.size() == 0) begin
               report_mismatch("response with nothing outstanding", 1, 0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", 32'(rsp_read_data), 32'(want.read_data));
               if (rsp_nak !== want.nak)
                  report_mismatch("nak", 32'(rsp_nak), 32'(want.nak));
               if (rsp_irq_n !== want.irq_n)
                  report_mismatch("irq_n", 32'(rsp_irq_n), 32'(want.irq_n));
            end
         end
      end
   end

   // Receiver: random stall runs, calm windows with no stalls, and one long hold-off
   // on request so that the block fills and pushes back on the request side.
   always begin
      @(negedge clock);
      rx_cycle++;
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
      end else if ((rx_cycle / 128) % 3 == 0) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(3, 0) == 0)
            stall_run = $urandom_range(5, 1);
      end
   end

   // Watchdog: ends the run when neither channel has moved a transfer for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("TIMEOUT: no transfer for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Routing bit, data-ready from an injection, status read clearing data-ready
   task automatic test_irq_path();
      send_req(OP_WR_START, 8'h00, 1'b0, 28'h0000000);
      send_req(OP_WR_BYTE, ADDR_ERRCFG, 1'b0, 28'h0000000);
      send_req(OP_WR_BYTE, 8'h01, 1'b1, 28'hFFFFFFF);      // ERRCFG bit 8 on
      send_req(OP_WR_BYTE, 8'h00, 1'b0, 28'h0000000);
      send_req(OP_INJECT, 8'hFF, 1'b1, 28'hFFFFFFF);       // irq asserts
      send_req(OP_WR_START, 8'h00, 1'b0, 28'h0000000);
      send_req(OP_WR_BYTE, ADDR_STATUS, 1'b0, 28'h0000000);
      send_req(OP_RD_START, 8'h00, 1'b0, 28'h0000000);
      send_req(OP_RD_BYTE, 8'h00, 1'b0, 28'h0000000);
      send_req(OP_RD_BYTE, 8'hFF, 1'b1, 28'hFFFFFFF);      // LSB read clears DRDY
      send_req(OP_INJECT, 8'h00, 1'b0, 28'h0000000);
   endtask

   // Write-protected ID word, pointer run-off past the map, ID readback
   task automatic test_protect_and_range();
      send_req(OP_WR_START, 8'h00, 1'b0, 28'h0000000);
      send_req(OP_WR_BYTE, ADDR_DEV_ID, 1'b0, 28'h0000000);
      send_req(OP_WR_BYTE, 8'h12, 1'b0, 28'h0000000);
      send_req(OP_WR_BYTE, 8'h34, 1'b0, 28'h0000000);      // pointer now past the map
      send_req(OP_WR_BYTE, 8'hAA, 1'b0, 28'h0000000);      // refused
      send_req(OP_RD_BYTE, 8'h00, 1'b0, 28'h0000000);      // reads zero
      send_req(OP_WR_START, 8'h00, 1'b0, 28'h0000000);
      send_req(OP_WR_BYTE, ADDR_MFR_ID, 1'b0, 28'h0000000);
      send_req(OP_RD_START, 8'h00, 1'b0, 28'h0000000);
      send_req(OP_RD_BYTE, 8'h00, 1'b0, 28'h0000000);
      send_req(OP_RD_BYTE, 8'h00, 1'b0, 28'h0000000);
   endtask

   // Bit 15 of 0x1C reloads the defaults; pointer carries on to 0x1D
   task automatic test_soft_reset();
      send_req(OP_WR_START, 8'h00, 1'b0, 28'h0000000);
      send_req(OP_WR_BYTE, ADDR_RESETDEV, 1'b0, 28'h0000000);
      send_req(OP_WR_BYTE, 8'h80, 1'b0, 28'h0000000);
      send_req(OP_WR_BYTE, 8'h00, 1'b0, 28'h0000000);
   endtask

   task automatic test_spare_ops();
      for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
         send_op(3'(k));
   endtask

   // Mostly well-formed write and read transactions with random content, plus
   // injections and raw noise; one long receiver hold-off part-way through.
   task automatic test_random_traffic();
      int base;
      int kind;
      int n;
      base = sent_count;
      while (sent_count - base < RANDOM_ITEMS) begin
         if (!hold_done && sent_count - base > RANDOM_ITEMS / 3) begin
            long_hold_req = 1'b1;
            hold_done     = 1'b1;
         end
         gaps_on = ((sent_count - base) / 90) % 2 == 0;
         kind = $urandom_range(99, 0);
         if (kind < 35) begin
            send_op(OP_WR_START);
            send_req(OP_WR_BYTE, pick_reg_ptr(), 1'($urandom), 28'($urandom));
            n = $urandom_range(6, 1);
            repeat (n) send_op(OP_WR_BYTE);
         end else if (kind < 65) begin
            if ($urandom_range(3, 0) != 0) begin
               send_op(OP_WR_START);
               send_req(OP_WR_BYTE, pick_reg_ptr(), 1'($urandom), 28'($urandom));
            end
            send_op(OP_RD_START);
            n = $urandom_range(8, 1);
            repeat (n) send_op(OP_RD_BYTE);
         end else if (kind < 80) begin
            send_op(OP_INJECT);
         end else begin
            send_op(3'($urandom_range(OP_SPARE_LAST, OP_WR_START)));
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_WR_START;
      req_bus_byte  = 8'h00;
      req_channel   = 1'b0;
      req_sample    = 28'h0000000;
      rsp_stall     = 1'b0;
      error_count   = 0;
      req_count     = 0;
      rsp_count     = 0;
      sent_count    = 0;
      inject_count  = 0;
      soft_reset_count = 0;
      nak_count     = 0;
      irq_low_count = 0;
      burst_left    = 0;
      gaps_on       = 1'b1;
      long_hold_req = 1'b0;
      hold_done     = 1'b0;
      rx_cycle      = 0;
      stall_run     = 0;
      load_bank_defaults();
      ptr_model   = 8'h00;
      lsb_next    = 1'b0;
      ptr_pending = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_irq_path();
      test_protect_and_range();
      test_soft_reset();
      test_spare_ops();
      test_random_traffic();
      req_valid <= 1'b0;

      // drain, then allow for anything stray to surface
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch("responses still outstanding", 32'(pending_rsp.size()), 0);

      $display("Covered %0d request / %0d response transfers: %0d injections, %0d soft resets",
               req_count, rsp_count, inject_count, soft_reset_count);
      $display("  %0d refused bytes, %0d responses with irq asserted, one long receiver hold",
               nak_count, irq_low_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> files.f
sv/isrb_pkg.sv
sv/isrb_ram.sv
sv/i2c_sensor_register_bank_core.sv
test/tb.sv
